>>> rtl/core/rti_pkg.sv
// Shared types and constants for the ray/triangle intersection core.
// No dependencies; every other file in this folder imports it.
package rti_pkg;

  localparam int CW   = 32;   // coordinate width
  localparam int EW   = 33;   // edge / origin-offset width
  localparam int PW   = 67;   // cross product component width
  localparam int W    = 104;  // dot product and numerator width
  localparam int SPL  = 34;   // split point of cross components for multiplies
  localparam int QW   = 31;   // distance width
  localparam int TAGW = 16;
  localparam int EPSW = 16;
  localparam int IDXW = 3;

  localparam logic [IDXW-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [IDXW-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [IDXW-1:0] REG_ORIGIN_Z    = 3'd2;
  localparam logic [IDXW-1:0] REG_DIRECTION_X = 3'd3;
  localparam logic [IDXW-1:0] REG_DIRECTION_Y = 3'd4;
  localparam logic [IDXW-1:0] REG_DIRECTION_Z = 3'd5;
  localparam logic [IDXW-1:0] REG_EPSILON     = 3'd6;

  localparam logic [QW-1:0] DIST_MAX = {QW{1'b1}};

  typedef struct packed {
    logic [2:0][EW-1:0] eab;
    logic [2:0][EW-1:0] eac;
    logic [2:0][EW-1:0] sv;
    logic [TAGW-1:0]    tag;
  } tri_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/core/rti_tri_if.sv
// Triangle input channel: valid/ready plus three vertices and a tag.
// Depends on rti_pkg.
interface rti_tri_if import rti_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CW-1:0]   a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  logic [TAGW-1:0] tri_tag;
  modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, tri_tag,
                 input ready);
  modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, tri_tag,
               output ready);
endinterface

>>> rtl/core/rti_res_if.sv
// Result channel: valid/ready plus hit flag, distance and tag.
// Depends on rti_pkg.
interface rti_res_if import rti_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            hit;
  logic [QW-1:0]   distance;
  logic [TAGW-1:0] result_tag;
  modport source(output valid, hit, distance, result_tag, input ready);
  modport sink(input valid, hit, distance, result_tag, output ready);
endinterface

>>> rtl/core/rti_cfg_if.sv
// Configuration write channel: valid/ready, register index and data.
// Depends on rti_pkg.
interface rti_cfg_if import rti_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IDXW-1:0] index;
  logic [CW-1:0]   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/core/ray_triangle_intersect_core.sv
// Ray/triangle intersection core (Moller-Trumbore, exact fixed point).
// Path from input accept to result valid: front register, queue, 38-stage arithmetic
//   pipeline and output register; one triangle per cycle while res_out is not stalled.
// The 31-stage restoring divider for t and the six multiply/sum stages set the depth.
// Reset (synchronous): pipeline and queue empty, ray at origin along +z, epsilon 1.
module ray_triangle_intersect_core import rti_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  rti_tri_if.sink    tri_in,
  rti_res_if.source  res_out,
  rti_cfg_if.sink    cfg
);

  logic [2:0][CW-1:0] origin;
  logic [2:0][CW-1:0] dir;
  logic [EPSW-1:0]    eps;

  logic      push;
  logic      pop;
  tri_item_t fr_item;
  tri_item_t head;
  q_stat_t   qstat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= '0;
      dir    <= {CW'(32'h0001_0000), CW'(0), CW'(0)};
      eps    <= EPSW'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ORIGIN_X:    origin[0] <= cfg.data;
        REG_ORIGIN_Y:    origin[1] <= cfg.data;
        REG_ORIGIN_Z:    origin[2] <= cfg.data;
        REG_DIRECTION_X: dir[0]    <= cfg.data;
        REG_DIRECTION_Y: dir[1]    <= cfg.data;
        REG_DIRECTION_Z: dir[2]    <= cfg.data;
        REG_EPSILON:     eps       <= cfg.data[EPSW-1:0];
        default: ;
      endcase
    end
  end

  rti_front u_front (
    .clk    (clk),
    .rst    (rst),
    .tri_in (tri_in),
    .origin (origin),
    .space  (!qstat.full),
    .push   (push),
    .item   (fr_item)
  );

  rti_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (fr_item),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  rti_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .qstat   (qstat),
    .pop     (pop),
    .dir     (dir),
    .eps     (eps),
    .res_out (res_out)
  );

`ifndef ASSERT_OFF
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && !res_out.hit |-> res_out.distance == '0)
    else $error("miss reported with nonzero distance");

  a_hit_beyond_eps: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res_out.hit |-> res_out.distance > QW'(eps))
    else $error("hit reported at distance not above epsilon");

  a_queue_after_reset: assert property (@(posedge clk)
    $past(rst) |-> qstat.empty && !res_out.valid)
    else $error("queue or output not empty after reset");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push)
    else $error("push into full queue");
`endif

endmodule

>>> rtl/core/rti_front.sv
// Front end: accepts triangles, forms edges and origin offset into one register.
// Depends on rti_pkg and rti_tri_if.
module rti_front import rti_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  rti_tri_if.sink            tri_in,
  input  logic [2:0][CW-1:0] origin,
  input  logic               space,
  output logic               push,
  output tri_item_t          item
);

  logic      fr_valid;
  tri_item_t fr_item;
  tri_item_t fr_next;
  logic      take;

  assign tri_in.ready = !fr_valid || space;
  assign take         = tri_in.valid && tri_in.ready;
  assign push         = fr_valid && space;
  assign item         = fr_item;

  always_comb begin
    fr_next.eab[0] = EW'($signed(tri_in.b_x)) - EW'($signed(tri_in.a_x));
    fr_next.eab[1] = EW'($signed(tri_in.b_y)) - EW'($signed(tri_in.a_y));
    fr_next.eab[2] = EW'($signed(tri_in.b_z)) - EW'($signed(tri_in.a_z));
    fr_next.eac[0] = EW'($signed(tri_in.c_x)) - EW'($signed(tri_in.a_x));
    fr_next.eac[1] = EW'($signed(tri_in.c_y)) - EW'($signed(tri_in.a_y));
    fr_next.eac[2] = EW'($signed(tri_in.c_z)) - EW'($signed(tri_in.a_z));
    fr_next.sv[0]  = EW'($signed(origin[0])) - EW'($signed(tri_in.a_x));
    fr_next.sv[1]  = EW'($signed(origin[1])) - EW'($signed(tri_in.a_y));
    fr_next.sv[2]  = EW'($signed(origin[2])) - EW'($signed(tri_in.a_z));
    fr_next.tag    = tri_in.tri_tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (take) begin
      fr_valid <= 1'b1;
    end else if (push) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_item <= fr_next;
    end
  end

endmodule

>>> rtl/core/rti_queue.sv
// Two-entry queue between the front end and the arithmetic pipeline.
// Depends on rti_pkg.
module rti_queue import rti_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tri_item_t push_item,
  input  logic      pop,
  output tri_item_t head,
  output q_stat_t   stat
);

  tri_item_t  mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign stat.full  = (cnt == 2'd2);
  assign stat.empty = (cnt == 2'd0);
  assign head       = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_item;
    end
  end

endmodule

>>> rtl/core/rti_back.sv
// Back end: cross/dot products, range tests and a bit-per-stage divider for t.
// Depends on rti_pkg and rti_res_if.
module rti_back import rti_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  tri_item_t          head,
  input  q_stat_t            qstat,
  output logic               pop,
  input  logic [2:0][CW-1:0] dir,
  input  logic [EPSW-1:0]    eps,
  rti_res_if.source          res_out
);

  localparam int NW = W + FRAC_BITS;
  localparam int NS = 7 + QW;

  logic adv;
  logic [NS-1:0] v;
  logic [TAGW-1:0] tg [NS];

  // stage 1: cross product terms
  logic signed [2*EW-1:0] m1p [6];
  logic signed [2*EW-1:0] m1q [6];
  logic [2:0][EW-1:0] eab1, eac1, sv1;
  // stage 2: cross products
  logic signed [PW-1:0] pv2 [3];
  logic signed [PW-1:0] qv2 [3];
  logic [2:0][EW-1:0] eab2, eac2, sv2;
  // stage 3: partial products of the dot terms
  logic signed [EW-1:0]        a_sel [12];
  logic signed [PW-1:0]        p_sel [12];
  logic signed [2*EW-1:0]      ph3 [12];
  logic signed [EW+SPL+1:0]    pl3 [12];
  // stage 4..6: dot terms, sums, sign fix
  logic signed [W-1:0] pr4 [12];
  logic signed [W-1:0] s5 [4];
  logic signed [W-1:0] det6, nu6, nv6, nt6;
  logic signed [W:0]   uv_sum;
  logic [W-1:0]        lim;
  logic [NW-1:0]       nsh;
  logic [W:0]          rem_init;
  // divider chain, index 0 written by stage 7
  logic [W:0]    rem [QW+1];
  logic [W-1:0]  dd  [QW+1];
  logic [QW-1:0] nlo [QW+1];
  logic [QW-1:0] qt  [QW+1];
  logic          okp [QW+1];
  logic          satp[QW+1];

  logic          hit_next;
  logic [QW-1:0] dist_next;

  assign adv = !res_out.valid || res_out.ready;
  assign pop = adv && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NS-2:0], !qstat.empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tg[0] <= head.tag;
      for (int s = 1; s < NS; s++) begin
        tg[s] <= tg[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1p[0] <= $signed(dir[1]) * $signed(head.eac[2]);
      m1p[1] <= $signed(dir[2]) * $signed(head.eac[1]);
      m1p[2] <= $signed(dir[2]) * $signed(head.eac[0]);
      m1p[3] <= $signed(dir[0]) * $signed(head.eac[2]);
      m1p[4] <= $signed(dir[0]) * $signed(head.eac[1]);
      m1p[5] <= $signed(dir[1]) * $signed(head.eac[0]);
      m1q[0] <= $signed(head.sv[1]) * $signed(head.eab[2]);
      m1q[1] <= $signed(head.sv[2]) * $signed(head.eab[1]);
      m1q[2] <= $signed(head.sv[2]) * $signed(head.eab[0]);
      m1q[3] <= $signed(head.sv[0]) * $signed(head.eab[2]);
      m1q[4] <= $signed(head.sv[0]) * $signed(head.eab[1]);
      m1q[5] <= $signed(head.sv[1]) * $signed(head.eab[0]);
      eab1 <= head.eab;
      eac1 <= head.eac;
      sv1  <= head.sv;
      for (int i = 0; i < 3; i++) begin
        pv2[i] <= PW'(m1p[2*i]) - PW'(m1p[2*i+1]);
        qv2[i] <= PW'(m1q[2*i]) - PW'(m1q[2*i+1]);
      end
      eab2 <= eab1;
      eac2 <= eac1;
      sv2  <= sv1;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_sel[i]   = $signed(eab2[i]);
      p_sel[i]   = pv2[i];
      a_sel[3+i] = $signed(sv2[i]);
      p_sel[3+i] = pv2[i];
      a_sel[6+i] = EW'($signed(dir[i]));
      p_sel[6+i] = qv2[i];
      a_sel[9+i] = $signed(eac2[i]);
      p_sel[9+i] = qv2[i];
    end
  end

  // split each cross component into a signed high part and an unsigned low part
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 12; k++) begin
        ph3[k] <= a_sel[k] * $signed(p_sel[k][PW-1:SPL]);
        pl3[k] <= a_sel[k] * $signed({1'b0, p_sel[k][SPL-1:0]});
        pr4[k] <= (W'(ph3[k]) <<< SPL) + W'(pl3[k]);
      end
      for (int j = 0; j < 4; j++) begin
        s5[j] <= pr4[3*j] + pr4[3*j+1] + pr4[3*j+2];
      end
      if (s5[0][W-1]) begin
        det6 <= -s5[0];
        nu6  <= -s5[1];
        nv6  <= -s5[2];
        nt6  <= -s5[3];
      end else begin
        det6 <= s5[0];
        nu6  <= s5[1];
        nv6  <= s5[2];
        nt6  <= s5[3];
      end
    end
  end

  assign uv_sum   = (W+1)'(nu6) + (W+1)'(nv6);
  assign lim      = W'(eps) << (2 * FRAC_BITS);
  assign nsh      = NW'(unsigned'(nt6)) << FRAC_BITS;
  assign rem_init = (W+1)'(nsh[NW-1:QW]);

  // stage 7: range tests and divider seed
  always_ff @(posedge clk) begin
    if (adv) begin
      okp[0]  <= (det6 != '0) && !(unsigned'(det6) < lim)
                 && !nu6[W-1] && !(det6 < nu6)
                 && !nv6[W-1] && !((W+1)'(det6) < uv_sum)
                 && (nt6 > 0);
      // quotient overflows 31 bits when the seed already reaches det
      satp[0] <= rem_init >= (W+1)'(unsigned'(det6));
      rem[0]  <= rem_init;
      dd[0]   <= det6;
      nlo[0]  <= nsh[QW-1:0];
      qt[0]   <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [W+1:0] r2;
    logic         ge;
    assign r2 = {rem[k], nlo[k][QW-1-k]};
    assign ge = r2 >= (W+2)'(dd[k]);
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1]  <= ge ? (W+1)'(r2 - (W+2)'(dd[k])) : (W+1)'(r2);
        qt[k+1]   <= {qt[k][QW-2:0], ge};
        dd[k+1]   <= dd[k];
        nlo[k+1]  <= nlo[k];
        okp[k+1]  <= okp[k];
        satp[k+1] <= satp[k];
      end
    end
  end

  always_comb begin
    hit_next  = okp[QW] && (satp[QW] || (qt[QW] > QW'(eps)));
    dist_next = '0;
    if (hit_next) begin
      dist_next = satp[QW] ? DIST_MAX : qt[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_out.valid <= 1'b0;
    end else if (adv) begin
      res_out.valid <= v[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_out.hit        <= hit_next;
      res_out.distance   <= dist_next;
      res_out.result_tag <= tg[NS-1];
    end
  end

endmodule

>>> tb/tb_ray_triangle_intersect_core.sv
// Testbench for the ray/triangle intersection core: directed and random triangles
// against several ray settings, checked by an exact 128-bit Moller-Trumbore predictor.
// Depends on rti_pkg and the rti_*_if interfaces.
`timescale 1ns / 1ps

class hit_scoreboard;
  logic [47:0] pending[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  function void note_triangle(logic h, logic [30:0] d, logic [15:0] tag);
    pending.push_back({h, d, tag});
  endfunction

  function void check_result(logic h, logic [30:0] d, logic [15:0] tag);
    logic [47:0] e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result hit=%0d dist=%0h tag=%0h", $time, h, d, tag);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e[47] !== h) begin
      $display("%0t: hit expected %0d actual %0d", $time, e[47], h);
      errors++;
    end
    if (e[46:16] !== d) begin
      $display("%0t: distance expected %0h actual %0h", $time, e[46:16], d);
      errors++;
    end
    if (e[15:0] !== tag) begin
      $display("%0t: tag expected %0h actual %0h", $time, e[15:0], tag);
      errors++;
    end
  endfunction
endclass

module tb_ray_triangle_intersect_core;
  import rti_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic burst_tri = 0, burst_res = 0;

  rti_tri_if tri_ch();
  rti_res_if res_ch();
  rti_cfg_if cfg_ch();

  ray_triangle_intersect_core i_dut (
    .clk(clk), .rst(rst), .tri_in(tri_ch.sink), .res_out(res_ch.source), .cfg(cfg_ch.sink)
  );

  always #10 clk = ~clk;

  hit_scoreboard sb = new();
  logic signed [31:0] ray_o[3], ray_d[3];
  logic [15:0] ray_eps;

  initial begin
    tri_ch.valid = 0; {tri_ch.a_x, tri_ch.a_y, tri_ch.a_z} = '0;
    {tri_ch.b_x, tri_ch.b_y, tri_ch.b_z, tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} = '0;
    tri_ch.tri_tag = 0;
    cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
    res_ch.ready = 0;
  end

  function automatic logic signed [127:0] sx(logic signed [31:0] v);
    return 128'(v);
  endfunction

  // Exact intersection test; returns {hit, distance}.
  function automatic logic [31:0] predict_hit(logic signed [31:0] v[9]);
    logic signed [127:0] e1[3], e2[3], s[3], dd[3], p[3], q[3];
    logic signed [127:0] det, nu, nv, nt, tq;
    logic [127:0] lim;
    for (int i = 0; i < 3; i++) begin
      e1[i] = sx(v[3+i]) - sx(v[i]);
      e2[i] = sx(v[6+i]) - sx(v[i]);
      s[i] = sx(ray_o[i]) - sx(v[i]);
      dd[i] = sx(ray_d[i]);
    end
    p[0] = dd[1]*e2[2] - dd[2]*e2[1];
    p[1] = dd[2]*e2[0] - dd[0]*e2[2];
    p[2] = dd[0]*e2[1] - dd[1]*e2[0];
    q[0] = s[1]*e1[2] - s[2]*e1[1];
    q[1] = s[2]*e1[0] - s[0]*e1[2];
    q[2] = s[0]*e1[1] - s[1]*e1[0];
    det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
    nu = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
    nv = dd[0]*q[0] + dd[1]*q[1] + dd[2]*q[2];
    nt = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
    if (det < 0) begin
      det = -det; nu = -nu; nv = -nv; nt = -nt;
    end
    lim = 128'(ray_eps) << 32;
    if (det != 0 && det >= $signed(lim) && nu >= 0 && nu <= det && nv >= 0
        && nu + nv <= det && nt > 0) begin
      tq = $signed(128'($unsigned(nt << 16) / $unsigned(det)));
      if (tq > $signed(128'(ray_eps)))
        return {1'b1, (tq > 128'sh7FFFFFFF) ? DIST_MAX : tq[30:0]};
    end
    return 32'd0;
  endfunction

  // Leave valid high; the caller drops it after the last write.
  task automatic write_reg(logic [IDXW-1:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_ORIGIN_X: ray_o[0] = val;
      REG_ORIGIN_Y: ray_o[1] = val;
      REG_ORIGIN_Z: ray_o[2] = val;
      REG_DIRECTION_X: ray_d[0] = val;
      REG_DIRECTION_Y: ray_d[1] = val;
      REG_DIRECTION_Z: ray_d[2] = val;
      REG_EPSILON: ray_eps = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_ray(logic [31:0] ox, oy, oz, dx, dy, dz, logic [31:0] eps);
    write_reg(REG_ORIGIN_X, ox); write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz); write_reg(REG_DIRECTION_X, dx);
    write_reg(REG_DIRECTION_Y, dy); write_reg(REG_DIRECTION_Z, dz);
    write_reg(REG_EPSILON, eps);
    cfg_ch.valid <= 0;
  endtask

  task automatic send_triangle(logic signed [31:0] v[9], logic [15:0] tag);
    logic [31:0] r;
    while (!burst_tri && $urandom_range(99) < 13) begin
      tri_ch.valid <= 0;
      @(posedge clk);
    end
    tri_ch.valid <= 1;
    {tri_ch.a_x, tri_ch.a_y, tri_ch.a_z} <= {v[0], v[1], v[2]};
    {tri_ch.b_x, tri_ch.b_y, tri_ch.b_z} <= {v[3], v[4], v[5]};
    {tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} <= {v[6], v[7], v[8]};
    tri_ch.tri_tag <= tag;
    do @(posedge clk); while (!tri_ch.ready);
    r = predict_hit(v);
    sb.note_triangle(r[31], r[30:0], tag);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // Result side: random stall, check at accept.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result(res_ch.hit, res_ch.distance, res_ch.result_tag);
    res_ch.ready <= rst ? 1'b0 : (burst_res || $urandom_range(99) >= 13);
  end

  // Small random coordinate near the ray, or full range noise.
  function automatic logic [31:0] coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(2*131072)) - 131072;
      default: return $signed($urandom_range(2*(1 << 24))) - (1 << 24);
    endcase
  endfunction

  task automatic random_triangles(int n);
    logic signed [31:0] v[9];
    int mode;
    for (int k = 0; k < n; k++) begin
      burst_tri = (k % 400) >= 300;
      burst_res = burst_tri;
      mode = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 2);
      for (int i = 0; i < 9; i++) v[i] = coord(mode);
      // Place the triangle around the ray line most of the time.
      if (mode != 0 && $urandom_range(3) != 0)
        for (int i = 0; i < 3; i++) begin
          v[i*3+0] = ray_o[0] + coord(mode);
          v[i*3+1] = ray_o[1] + coord(mode);
        end
      send_triangle(v, $urandom);
    end
    tri_ch.valid <= 0;
    burst_tri = 0; burst_res = 0;
  endtask

  initial begin
    logic signed [31:0] v[9];
    ray_o = '{0, 0, 0}; ray_d = '{0, 0, 65536}; ray_eps = 1;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset ray: unit triangle at z = 2, hit, tag extremes.
    v = '{-65536, -65536, 131072, 65536, -65536, 131072, -65536, 65536, 131072};
    send_triangle(v, 16'h0000);
    send_triangle(v, 16'hFFFF);
    // Behind the origin.
    v = '{-65536, -65536, -131072, 65536, -65536, -131072, -65536, 65536, -131072};
    send_triangle(v, 1);
    // Degenerate: collinear vertices.
    v = '{0, 0, 65536, 65536, 65536, 65536, 131072, 131072, 65536};
    send_triangle(v, 2);
    // Ray passing exactly through a vertex and an edge.
    v = '{0, 0, 65536, 65536, 0, 65536, 0, 65536, 65536};
    send_triangle(v, 3);
    v = '{-65536, 0, 65536, 65536, 0, 65536, 0, 65536, 65536};
    send_triangle(v, 4);
    // Outside in u and in v.
    v = '{65536, 65536, 65536, 131072, 65536, 65536, 65536, 131072, 65536};
    send_triangle(v, 5);
    // Far plane at the top of the z range; the ray passes just outside the triangle.
    v = '{-2147483648, -2147483648, 2147483647, 2147483647, -2147483648, 2147483647,
          -2147483648, 2147483647, 2147483647};
    send_triangle(v, 6);
    // Full-range extremes.
    v = '{2147483647, 2147483647, 2147483647, -2147483648, -2147483648, -2147483648,
          2147483647, -2147483648, 0};
    send_triangle(v, 7);
    // Very close plane: t equal to epsilon, so no hit.
    v = '{-65536, -65536, 1, 65536, -65536, 1, -65536, 65536, 1};
    send_triangle(v, 8);
    tri_ch.valid <= 0;
    drain();

    // Zero epsilon, oblique ray with tiny determinant.
    set_ray(32'h0000_8000, 32'hFFFF_8000, 32'hFFFE_0000, 1, 1, 3, 0);
    v = '{-65536, -65536, 131072, 65536, -65536, 131072, -65536, 65536, 131072};
    send_triangle(v, 9);
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_triangle(v, 10);
    random_triangles(200);
    drain();

    // Maximum epsilon and extreme registers.
    set_ray(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h0000_FFFF);
    random_triangles(150);
    drain();

    // Random rays, moderate epsilon.
    for (int r = 0; r < 4; r++) begin
      set_ray(coord(2), coord(2), coord(2), coord(1), coord(1), coord(1),
              $urandom_range(64));
      random_triangles(200);
      drain();
    end
    set_ray(0, 0, 0, 0, 0, 65536, 1);
    random_triangles(50);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
